// ===== hw/rtl/icdf_pkg.sv =====
// Shared constants, types and the control program of the inverse-CDF size sampler.
package icdf_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   // Field widths.
   localparam int SIZE_W  = 31;
   localparam int PROB_W  = 32;
   localparam int DRAW_W  = 31;
   localparam int BPP_W   = 16;
   localparam int PROD_W  = SIZE_W + BPP_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Largest size that the block reports, 2^30.
   localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(31'h4000_0000);

   // Register reset values.
   localparam logic [CNT_W-1:0] ENTRIES_RESET = CNT_W'(1);
   localparam logic [BPP_W-1:0] BPP_RESET     = BPP_W'(1460);

   // Item modes.
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENTRIES_IN_USE   = 2'd0,
      CSR_PACKET_MODE      = 2'd1,
      CSR_BYTES_PER_PACKET = 2'd2
   } csr_index_type;

   // Datapath operations selected by a control word.
   typedef enum logic [2:0] {
      OP_NOP,
      OP_INIT,
      OP_RD_PROB,
      OP_CMP,
      OP_RD_SIZE,
      OP_MUL,
      OP_OUT
   } op_type;

   // How the step counter moves after a control word.
   typedef enum logic [2:0] {
      COND_NEXT,         // advance to the following step
      COND_JUMP,         // always go to the target
      COND_SEARCH_DONE,  // go to the target once the range has closed
      COND_WAIT_SAMPLE,  // hold until a sample item is taken, then advance
      COND_WAIT_OUT      // hold until the result register is free, then jump
   } cond_type;

   localparam int PC_W = 3;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } uword_type;

   // Status fed back from the datapath to the sequencer.
   typedef struct packed {
      logic sample_taken;
      logic search_done;
      logic out_free;
   } status_type;

   // Control driven from the sequencer into the datapath.
   typedef struct packed {
      op_type op;
      logic   idle;
   } ctrl_type;

   // Program step numbers.
   localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(0);
   localparam logic [PC_W-1:0] PC_INIT  = PC_W'(1);
   localparam logic [PC_W-1:0] PC_PROBE = PC_W'(2);
   localparam logic [PC_W-1:0] PC_CMP   = PC_W'(3);
   localparam logic [PC_W-1:0] PC_SIZE  = PC_W'(4);
   localparam logic [PC_W-1:0] PC_MUL   = PC_W'(5);
   localparam logic [PC_W-1:0] PC_OUT   = PC_W'(6);

   // The control program, one word per step.
   function automatic uword_type program_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{op: OP_NOP, cond: COND_JUMP, target: PC_IDLE};
      case (pc)
         PC_IDLE:  w = '{op: OP_NOP,     cond: COND_WAIT_SAMPLE, target: PC_IDLE};
         PC_INIT:  w = '{op: OP_INIT,    cond: COND_NEXT,        target: PC_IDLE};
         PC_PROBE: w = '{op: OP_RD_PROB, cond: COND_SEARCH_DONE, target: PC_SIZE};
         PC_CMP:   w = '{op: OP_CMP,     cond: COND_JUMP,        target: PC_PROBE};
         PC_SIZE:  w = '{op: OP_RD_SIZE, cond: COND_NEXT,        target: PC_IDLE};
         PC_MUL:   w = '{op: OP_MUL,     cond: COND_NEXT,        target: PC_IDLE};
         PC_OUT:   w = '{op: OP_OUT,     cond: COND_WAIT_OUT,    target: PC_IDLE};
         default:  w = '{op: OP_NOP,     cond: COND_JUMP,        target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/icdf_if.sv =====
// Channel interfaces of the inverse-CDF size sampler.
interface icdf_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic [icdf_pkg::IDX_W-1:0]        entry_index;
   logic [icdf_pkg::SIZE_W-1:0]       entry_size;
   logic [icdf_pkg::PROB_W-1:0]       entry_cum_prob;
   logic [icdf_pkg::DRAW_W-1:0]       draw;

   modport source (output valid, mode, entry_index, entry_size, entry_cum_prob, draw,
                   input ready);
   modport sink (input valid, mode, entry_index, entry_size, entry_cum_prob, draw,
                 output ready);
endinterface

interface icdf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [icdf_pkg::SIZE_W-1:0] msg_size;
   logic                        saturated;

   modport source (output valid, msg_size, saturated, input ready);
   modport sink (input valid, msg_size, saturated, output ready);
endinterface

interface icdf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [icdf_pkg::CSR_IDX_W-1:0]  index;
   logic [icdf_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/icdf_seq.sv =====
// Microcode sequencer: step counter, program table and jump conditions.
module icdf_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  icdf_pkg::status_type status,
   output icdf_pkg::ctrl_type   ctrl
);

   logic [icdf_pkg::PC_W-1:0] pc_ff;
   logic [icdf_pkg::PC_W-1:0] pc_in;
   icdf_pkg::uword_type       word;

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= icdf_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Fetch the control word and pick the next step.
   always_comb begin
      word  = icdf_pkg::program_rom(pc_ff);
      pc_in = pc_ff + 1'b1;
      case (word.cond)
         icdf_pkg::COND_NEXT: begin
            pc_in = pc_ff + 1'b1;
         end
         icdf_pkg::COND_JUMP: begin
            pc_in = word.target;
         end
         icdf_pkg::COND_SEARCH_DONE: begin
            pc_in = status.search_done ? word.target : pc_ff + 1'b1;
         end
         icdf_pkg::COND_WAIT_SAMPLE: begin
            pc_in = status.sample_taken ? pc_ff + 1'b1 : pc_ff;
         end
         icdf_pkg::COND_WAIT_OUT: begin
            pc_in = status.out_free ? word.target : pc_ff;
         end
         default: begin
            pc_in = icdf_pkg::PC_IDLE;
         end
      endcase
      ctrl.op   = word.op;
      ctrl.idle = (pc_ff == icdf_pkg::PC_IDLE);
   end

endmodule

// ===== hw/rtl/inverse_cdf_size_sampler.sv =====
// Top level of the inverse-CDF size sampler: registers, table memories and datapath.
//
// Channels: req_ch takes items; mode 0 loads one table entry (size and cumulative
// probability) at entry_index, mode 1 draws one sample with the uniform value draw.
// rsp_ch returns one item per sample: msg_size and the saturated flag. csr_ch
// writes entries_in_use (0), packet_mode (1) and bytes_per_packet (2); it is always
// ready. The user must write it only while the block is idle; the block does not enforce it.
// Sequence: a load is taken while idle and gives no result. A sample binary-
// searches the entries in use with at most ceil(log2(entries in use)) probes,
// each a memory read step and then a compare step; the entry size is then read,
// scaled and written to the output register, and the next item is taken once the
// sequencer is back in idle. The single read port of the probability memory and the
// registered read data set the separate read and compare steps of each probe.
// A finished result waits in the output register while the next item is taken;
// if the receiver stalls, a second sample completes its search and then holds
// in its last step until the output register frees.
// Reset: entries_in_use goes to 1, packet_mode to 0, bytes_per_packet to 1460 and
// the sequencer to idle. The table memories are not cleared; load each entry
// before a sample may reach it.
module inverse_cdf_size_sampler (
   input  logic      clock,
   input  logic      reset,
   icdf_req_if.sink   req_ch,
   icdf_rsp_if.source rsp_ch,
   icdf_csr_if.sink   csr_ch
);

   // Configuration registers.
   logic [icdf_pkg::CNT_W-1:0] entries_ff;
   logic                       packet_mode_ff;
   logic [icdf_pkg::BPP_W-1:0] bpp_ff;

   // Table memories and their registered read data.
   logic [icdf_pkg::SIZE_W-1:0] size_mem [icdf_pkg::TABLE_DEPTH];
   logic [icdf_pkg::PROB_W-1:0] prob_mem [icdf_pkg::TABLE_DEPTH];
   logic [icdf_pkg::SIZE_W-1:0] size_rd_ff;
   logic [icdf_pkg::PROB_W-1:0] prob_rd_ff;

   // Search and result datapath.
   logic [icdf_pkg::DRAW_W-1:0] draw_ff;
   logic [icdf_pkg::IDX_W-1:0]  lo_ff;
   logic [icdf_pkg::IDX_W-1:0]  hi_ff;
   logic [icdf_pkg::PROD_W-1:0] prod_ff;
   logic                        rsp_valid_ff;
   logic [icdf_pkg::SIZE_W-1:0] msg_size_ff;
   logic                        saturated_ff;

   logic [icdf_pkg::CNT_W-1:0]  active_cnt;
   logic [icdf_pkg::CNT_W-1:0]  mid_sum;
   logic [icdf_pkg::IDX_W-1:0]  mid;
   logic [icdf_pkg::BPP_W-1:0]  factor;
   logic                        req_fire;
   logic                        draw_le;
   logic                        over_limit;

   icdf_pkg::status_type status;
   icdf_pkg::ctrl_type   ctrl;

   icdf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Handshakes and status back to the sequencer.
   assign req_ch.ready = ctrl.idle;
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign status.sample_taken = req_fire && (req_ch.mode == icdf_pkg::MODE_SAMPLE);
   assign status.search_done  = (lo_ff >= hi_ff);
   assign status.out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Entry count clamped to 1..TABLE_DEPTH.
   always_comb begin
      active_cnt = entries_ff;
      if (entries_ff == '0) begin
         active_cnt = icdf_pkg::CNT_W'(1);
      end else if (entries_ff > icdf_pkg::CNT_W'(icdf_pkg::TABLE_DEPTH)) begin
         active_cnt = icdf_pkg::CNT_W'(icdf_pkg::TABLE_DEPTH);
      end
   end

   // Probe position and comparison against the draw.
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = mid_sum[icdf_pkg::IDX_W:1];
   assign draw_le    = ({1'b0, draw_ff} <= prob_rd_ff);
   assign factor     = packet_mode_ff ? bpp_ff : icdf_pkg::BPP_W'(1);
   assign over_limit = (prod_ff > icdf_pkg::PROD_W'(icdf_pkg::SIZE_LIMIT));

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff     <= icdf_pkg::ENTRIES_RESET;
         packet_mode_ff <= 1'b0;
         bpp_ff         <= icdf_pkg::BPP_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (icdf_pkg::csr_index_type'(csr_ch.index))
            icdf_pkg::CSR_ENTRIES_IN_USE: begin
               entries_ff <= csr_ch.data[icdf_pkg::CNT_W-1:0];
            end
            icdf_pkg::CSR_PACKET_MODE: begin
               packet_mode_ff <= csr_ch.data[0];
            end
            icdf_pkg::CSR_BYTES_PER_PACKET: begin
               bpp_ff <= csr_ch.data;
            end
            default: begin
            end
         endcase
      end
   end

   // Table memories: loads write, search steps read.
   always_ff @(posedge clock) begin
      if (req_fire && (req_ch.mode == icdf_pkg::MODE_LOAD)) begin
         size_mem[req_ch.entry_index] <= req_ch.entry_size;
         prob_mem[req_ch.entry_index] <= req_ch.entry_cum_prob;
      end
      if (ctrl.op == icdf_pkg::OP_RD_PROB) begin
         prob_rd_ff <= prob_mem[mid];
      end
      if (ctrl.op == icdf_pkg::OP_RD_SIZE) begin
         size_rd_ff <= size_mem[hi_ff];
      end
   end

   // Search range, scaling product and draw capture.
   always_ff @(posedge clock) begin
      if (status.sample_taken) begin
         draw_ff <= req_ch.draw;
      end
      case (ctrl.op)
         icdf_pkg::OP_INIT: begin
            lo_ff <= '0;
            hi_ff <= icdf_pkg::IDX_W'(active_cnt - 1'b1);
         end
         icdf_pkg::OP_CMP: begin
            if (draw_le) begin
               hi_ff <= mid;
            end else begin
               lo_ff <= icdf_pkg::IDX_W'(mid + 1'b1);
            end
         end
         icdf_pkg::OP_MUL: begin
            prod_ff <= size_rd_ff * factor;
         end
         default: begin
         end
      endcase
   end

   // Output register with saturation at 2^30.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((ctrl.op == icdf_pkg::OP_OUT) && status.out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((ctrl.op == icdf_pkg::OP_OUT) && status.out_free) begin
         msg_size_ff  <= over_limit ? icdf_pkg::SIZE_LIMIT : prod_ff[icdf_pkg::SIZE_W-1:0];
         saturated_ff <= over_limit;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.msg_size  = msg_size_ff;
   assign rsp_ch.saturated = saturated_ff;

`ifndef ASSERT_OFF
   // A compare step only runs on a range that is still open.
   a_cmp_open: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == icdf_pkg::OP_CMP) |-> (lo_ff < hi_ff))
      else $error("compare step on a closed search range");

   // The search always closes on a single entry before the size is read.
   a_search_closed: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == icdf_pkg::OP_RD_SIZE) |-> (lo_ff == hi_ff))
      else $error("size read before the search range closed");

   // A saturated result carries exactly the size limit.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && saturated_ff) |-> (msg_size_ff == icdf_pkg::SIZE_LIMIT))
      else $error("saturated result without the limit value");
`endif

endmodule
